>>> src/sfx_pkg.sv
// Shared types and constants for the SPI slave byte exchanger.
package sfx_pkg;

    // Event codes carried in the mode field.
    localparam logic [1:0] MODE_XFER = 2'd0;
    localparam logic [1:0] MODE_PUT  = 2'd1;
    localparam logic [1:0] MODE_GET  = 2'd2;

    // Byte shifted out when the transmit queue runs dry, and the one after reset.
    localparam logic [7:0] FILLER_BYTE = 8'd200;
    localparam logic [7:0] RESET_NEXT  = 8'd201;

    // Width of the level fields on the result.
    localparam int LEVEL_W = 5;

    typedef struct packed {
        logic [1:0] mode;
        logic [7:0] rx_byte;
        logic [7:0] tx_data;
    } sfx_req_t;

    typedef struct packed {
        logic [7:0]         shift_byte;
        logic               ok;
        logic [7:0]         read_byte;
        logic               rx_dropped;
        logic [LEVEL_W-1:0] tx_level;
        logic [LEVEL_W-1:0] rx_level;
    } sfx_rsp_t;

    // Command broadcast to every cell of one queue.
    typedef struct packed {
        logic       push;
        logic       pop;
        logic [7:0] din;
    } sfx_cmd_t;

    // What one cell shows to its neighbors.
    typedef struct packed {
        logic       occ;
        logic [7:0] data;
    } sfx_link_t;

endpackage

>>> src/spi_slave_byte_fifo_exchange.sv
// Top level of the SPI slave byte exchanger with transmit and receive queues.
//
// The req channel carries one event per transaction: a completed SPI transfer
// (mode 0) with the byte just received, a host put (mode 1) of a byte to
// send, or a host get (mode 2). Mode 3 does nothing but report the levels.
// Every accepted transaction gives exactly one rsp transaction holding the
// byte for the shift register, the ok flag, the byte read, the drop flag and
// both queue levels after the event.
// The response is registered at the edge that accepts the request. One request
// can be taken every cycle while req_ready is high; each queue is a row of
// cells that shifts or loads at that same edge, so the queues never limit the rate.
// When rsp is stalled a skid register holds one more response, so a request
// is still taken while a response waits; with both full, req_ready drops.
// Reset empties both queues and sets the held next byte to 201; a transfer
// with an empty transmit queue loads the filler byte 200 into the held slot.
module spi_slave_byte_fifo_exchange
    import sfx_pkg::*;
#(
    parameter int TX_DEPTH = 16,
    parameter int RX_DEPTH = 16
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     req_valid,
    output logic     req_ready,
    input  sfx_req_t req,
    output logic     rsp_valid,
    input  logic     rsp_ready,
    output sfx_rsp_t rsp
);

    localparam int TX_CNT_W = $clog2(TX_DEPTH + 1);
    localparam int RX_CNT_W = $clog2(RX_DEPTH + 1);

    sfx_cmd_t         tx_cmd;
    sfx_cmd_t         rx_cmd;
    logic [7:0]       tx_head;
    logic [7:0]       rx_head;
    logic [TX_CNT_W-1:0] tx_lvl;
    logic [RX_CNT_W-1:0] rx_lvl;
    logic [TX_CNT_W-1:0] tx_lvl_after;
    logic [RX_CNT_W-1:0] rx_lvl_after;
    logic             tx_full;
    logic             tx_empty;
    logic             rx_full;
    logic             rx_empty;

    logic             req_fire;
    logic             rsp_fire;
    sfx_rsp_t         res;

    logic [7:0]       held_reg;
    logic [7:0]       held_next;
    logic             out_valid_reg;
    logic             out_valid_next;
    sfx_rsp_t         out_data_reg;
    sfx_rsp_t         out_data_next;
    logic             skid_valid_reg;
    logic             skid_valid_next;
    sfx_rsp_t         skid_reg;
    sfx_rsp_t         skid_next;

    assign req_ready = !skid_valid_reg;
    assign req_fire  = req_valid && req_ready;
    assign rsp_fire  = out_valid_reg && rsp_ready;

    // Decode the event into queue commands and build the response.
    always_comb
    begin
        tx_cmd       = '0;
        rx_cmd       = '0;
        tx_cmd.din   = req.tx_data;
        rx_cmd.din   = req.rx_byte;
        held_next    = held_reg;
        res          = '0;
        tx_lvl_after = tx_lvl;
        rx_lvl_after = rx_lvl;
        unique case (req.mode)
            MODE_XFER:
            begin
                res.shift_byte = held_reg;
                res.ok         = 1'b1;
                tx_cmd.pop     = req_fire && !tx_empty;
                held_next      = tx_empty ? FILLER_BYTE : tx_head;
                rx_cmd.push    = req_fire && !rx_full;
                res.rx_dropped = rx_full;
                if (!tx_empty)
                begin
                    tx_lvl_after = TX_CNT_W'(tx_lvl - 1'b1);
                end
                if (!rx_full)
                begin
                    rx_lvl_after = RX_CNT_W'(rx_lvl + 1'b1);
                end
            end
            MODE_PUT:
            begin
                tx_cmd.push = req_fire && !tx_full;
                res.ok      = !tx_full;
                if (!tx_full)
                begin
                    tx_lvl_after = TX_CNT_W'(tx_lvl + 1'b1);
                end
            end
            MODE_GET:
            begin
                rx_cmd.pop    = req_fire && !rx_empty;
                res.ok        = !rx_empty;
                res.read_byte = rx_empty ? 8'd0 : rx_head;
                if (!rx_empty)
                begin
                    rx_lvl_after = RX_CNT_W'(rx_lvl - 1'b1);
                end
            end
            default:
            begin
                res.ok = 1'b0;
            end
        endcase
        res.tx_level = LEVEL_W'(tx_lvl_after);
        res.rx_level = LEVEL_W'(rx_lvl_after);
        if (!req_fire)
        begin
            held_next = held_reg;
        end
    end

    sfx_fifo #(
        .DEPTH (TX_DEPTH)
    ) u_tx_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (tx_cmd),
        .head  (tx_head),
        .level (tx_lvl),
        .full  (tx_full),
        .empty (tx_empty)
    );

    sfx_fifo #(
        .DEPTH (RX_DEPTH)
    ) u_rx_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (rx_cmd),
        .head  (rx_head),
        .level (rx_lvl),
        .full  (rx_full),
        .empty (rx_empty)
    );

    // Output register with a skid stage behind it.
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_next       = skid_reg;
        if (skid_valid_reg)
        begin
            if (rsp_fire)
            begin
                out_data_next   = skid_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (req_fire)
        begin
            if (!out_valid_reg || rsp_fire)
            begin
                out_data_next  = res;
                out_valid_next = 1'b1;
            end
            else
            begin
                skid_next       = res;
                skid_valid_next = 1'b1;
            end
        end
        else if (rsp_fire)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg       <= RESET_NEXT;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            held_reg       <= held_next;
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
        skid_reg     <= skid_next;
    end

    assign rsp_valid = out_valid_reg;
    assign rsp       = out_data_reg;

    // A waiting skid entry always sits behind a valid output entry.
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry held without an output entry");

    // Queue levels never pass their depths.
    a_levels_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        (32'(tx_lvl) <= TX_DEPTH) && (32'(rx_lvl) <= RX_DEPTH))
        else $error("queue level beyond depth");

    // A transfer refills the held byte from the queue head or the filler.
    a_held_refill: assert property (@(posedge clk) disable iff (!rst_n)
        (req_fire && req.mode == MODE_XFER) |=>
        held_reg == ($past(tx_empty) ? FILLER_BYTE : $past(tx_head)))
        else $error("held byte not refilled correctly");

    // The level counters agree with the occupancy of the head cells.
    a_empty_matches_level: assert property (@(posedge clk) disable iff (!rst_n)
        (tx_empty == (tx_lvl == '0)) && (rx_empty == (rx_lvl == '0)))
        else $error("queue level disagrees with head cell");

endmodule

>>> src/sfx_cell.sv
// One storage cell of a shifting byte queue.
module sfx_cell
    import sfx_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  sfx_cmd_t  cmd,
    input  logic      prev_occ,
    input  sfx_link_t nbr,
    output sfx_link_t link
);

    logic       occ_reg;
    logic       occ_next;
    logic [7:0] data_reg;
    logic [7:0] data_next;

    // A pop moves every entry one cell toward the head; a push lands in the
    // first empty cell, the one whose lower neighbor is occupied.
    always_comb
    begin
        occ_next  = occ_reg;
        data_next = data_reg;
        if (cmd.pop)
        begin
            occ_next  = nbr.occ;
            data_next = nbr.data;
        end
        else if (cmd.push && !occ_reg && prev_occ)
        begin
            occ_next  = 1'b1;
            data_next = cmd.din;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg <= 1'b0;
        end
        else
        begin
            occ_reg <= occ_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign link.occ  = occ_reg;
    assign link.data = data_reg;

endmodule

>>> src/sfx_fifo.sv
// Byte queue built as a row of shifting cells with a level counter.
module sfx_fifo
    import sfx_pkg::*;
#(
    parameter int DEPTH = 16,
    parameter int CNT_W = $clog2(DEPTH + 1)
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  sfx_cmd_t         cmd,
    output logic [7:0]       head,
    output logic [CNT_W-1:0] level,
    output logic             full,
    output logic             empty
);

    sfx_link_t        cells [DEPTH];
    logic [CNT_W-1:0] level_reg;
    logic [CNT_W-1:0] level_next;

    // The row of cells; cell 0 is the head of the queue.
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        sfx_link_t nbr;
        logic      prev_occ;

        if (i == DEPTH - 1)
        begin : g_last
            assign nbr = '0;
        end
        else
        begin : g_mid
            assign nbr = cells[i+1];
        end

        if (i == 0)
        begin : g_first
            assign prev_occ = 1'b1;
        end
        else
        begin : g_rest
            assign prev_occ = cells[i-1].occ;
        end

        sfx_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .cmd      (cmd),
            .prev_occ (prev_occ),
            .nbr      (nbr),
            .link     (cells[i])
        );
    end

    // Level counter; push and pop never come together.
    always_comb
    begin
        level_next = level_reg;
        if (cmd.push)
        begin
            level_next = CNT_W'(level_reg + 1'b1);
        end
        else if (cmd.pop)
        begin
            level_next = CNT_W'(level_reg - 1'b1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_reg <= '0;
        end
        else
        begin
            level_reg <= level_next;
        end
    end

    assign head  = cells[0].data;
    assign level = level_reg;
    assign empty = !cells[0].occ;
    assign full  = cells[DEPTH-1].occ;

endmodule
